@@ hw/rtl/sqc_pkg.sv @@
// Shared widths, constants and types for the stress invariant pipeline.
package sqc_pkg;
  localparam int DataW   = 32;            // component word width
  localparam int DevW    = DataW + 1;     // exact deviatoric width
  localparam int SumW    = DataW + 2;     // trace width
  localparam int SqW     = 2 * DevW;      // lane square width
  localparam int AccW    = SqW + 1;       // double-dot sum width
  localparam int SqInW   = AccW + 1;      // radicand width, 1.5x scaled
  localparam int RootW   = DataW - 1;     // result root width
  localparam int RadW    = 2 * RootW;     // radicand bits kept below saturation
  localparam int RemW    = RootW + 4;     // root remainder width
  localparam int NumLane = 6;
  localparam int MulSplit = 17;           // reciprocal split point
  localparam int DivShift = 35;           // reciprocal scale 2^35
  localparam logic [33:0] Div3Mul = 34'h2_AAAA_AAAB;   // ceil(2^35 / 3)

  // Payload that rides alongside the root pipelines
  typedef struct packed {
    logic [DataW-1:0] mean;
    logic [DataW-1:0] dev_xx;
    logic [DataW-1:0] dev_yy;
    logic [DataW-1:0] dev_zz;
  } pay_t;
endpackage

@@ hw/rtl/sqc_mean.sv @@
// Mean stress: trace over three toward zero, three pipeline stages.
module sqc_mean (
  input  logic                      clk,
  input  logic [sqc_pkg::DataW-1:0] in_xx,
  input  logic [sqc_pkg::DataW-1:0] in_yy,
  input  logic [sqc_pkg::DataW-1:0] in_zz,
  output logic [sqc_pkg::DataW-1:0] out_mean
);
  import sqc_pkg::*;

  logic signed [SumW-1:0]          trace;
  logic [SumW-1:0]                 mag_r;
  logic                            neg_r, neg2_r;
  logic [SumW+MulSplit-1:0]        plo_r, phi_r;
  logic [SumW+2*MulSplit-1:0]      prod;
  logic [DataW-1:0]                quo;
  logic [DataW-1:0]                mean_r;

  // Sum the normals and take magnitude
  assign trace = SumW'($signed(in_xx)) + SumW'($signed(in_yy)) + SumW'($signed(in_zz));

  always_ff @(posedge clk) begin
    mag_r <= trace[SumW-1] ? SumW'(-trace) : SumW'(trace);
    neg_r <= trace[SumW-1];
  end

  // Multiply by reciprocal of three in two partial products
  always_ff @(posedge clk) begin
    plo_r  <= mag_r * Div3Mul[MulSplit-1:0];
    phi_r  <= mag_r * Div3Mul[2*MulSplit-1:MulSplit];
    neg2_r <= neg_r;
  end

  // Combine partials, restore sign
  assign prod = (SumW+2*MulSplit)'(plo_r) + {phi_r, {MulSplit{1'b0}}};
  assign quo  = prod[DivShift+DataW-1:DivShift];

  always_ff @(posedge clk) begin
    mean_r <= neg2_r ? DataW'(-quo) : quo;
  end

  assign out_mean = mean_r;
endmodule

@@ hw/rtl/sqc_lane.sv @@
// One squaring lane: registered square of a signed component's magnitude.
module sqc_lane (
  input  logic                    clk,
  input  logic [sqc_pkg::DevW-1:0] in_val,
  output logic [sqc_pkg::SqW-1:0]  out_sq
);
  import sqc_pkg::*;

  logic [DevW-1:0] mag;
  logic [SqW-1:0]  sq_r;

  // Take magnitude, square it
  assign mag = in_val[DevW-1] ? DevW'(-in_val) : in_val;

  always_ff @(posedge clk) begin
    sq_r <= mag * mag;
  end

  assign out_sq = sq_r;
endmodule

@@ hw/rtl/sqc_isqrt.sv @@
// Pipelined floor square root, one result bit per stage, with saturation flag.
module sqc_isqrt (
  input  logic                       clk,
  input  logic [sqc_pkg::SqInW-1:0]  in_x,
  output logic [sqc_pkg::RootW-1:0]  out_root,
  output logic                       out_sat
);
  import sqc_pkg::*;

  logic [RemW-1:0]  rem_r  [0:RootW-1];
  logic [RootW-1:0] root_r [0:RootW-1];
  logic [RadW-1:0]  xs_r   [0:RootW-1];
  logic             sat_r  [0:RootW-1];

  logic [RemW-1:0]  rem_p  [0:RootW-1];
  logic [RootW-1:0] root_p [0:RootW-1];
  logic [RadW-1:0]  xs_p   [0:RootW-1];
  logic             sat_p  [0:RootW-1];

  // Feed first stage from input, later stages from the previous one
  assign rem_p[0]  = '0;
  assign root_p[0] = '0;
  assign xs_p[0]   = in_x[RadW-1:0];
  assign sat_p[0]  = |in_x[SqInW-1:RadW];

  genvar k;
  generate
    for (k = 1; k < RootW; k++) begin : g_link
      assign rem_p[k]  = rem_r[k-1];
      assign root_p[k] = root_r[k-1];
      assign xs_p[k]   = xs_r[k-1];
      assign sat_p[k]  = sat_r[k-1];
    end

    for (k = 0; k < RootW; k++) begin : g_stage
      logic [RemW-1:0] rem_sh;
      logic [RemW-1:0] trial;
      logic            take;

      // Bring down two bits, try subtracting 4*root+1
      assign rem_sh = {rem_p[k][RemW-3:0], xs_p[k][RadW-1 -: 2]};
      assign trial  = RemW'({root_p[k], 2'b01});
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        rem_r[k]  <= take ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_p[k][RootW-2:0], take};
        xs_r[k]   <= {xs_p[k][RadW-3:0], 2'b00};
        sat_r[k]  <= sat_p[k];
      end
    end
  endgenerate

  assign out_root = root_r[RootW-1];
  assign out_sat  = sat_r[RootW-1];
endmodule

@@ hw/rtl/stress_invariants_p_q.sv @@
// Top level: each accepted item flows through the pipeline to out_strobe.
// Throughput one item per cycle; busy is always low.
// The longest part of the path is the 31-stage bit-per-stage square root pipelines.
// Results cannot be stalled; each shows for one cycle with out_strobe.
// Synchronous active-low reset clears only the valid pipeline.
module stress_invariants_p_q (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sqc_pkg::DataW-1:0] in_stress_xx,
  input  logic signed [sqc_pkg::DataW-1:0] in_stress_yy,
  input  logic signed [sqc_pkg::DataW-1:0] in_stress_zz,
  input  logic signed [sqc_pkg::DataW-1:0] in_shear_a,
  input  logic signed [sqc_pkg::DataW-1:0] in_shear_b,
  input  logic signed [sqc_pkg::DataW-1:0] in_shear_c,
  output logic                             out_strobe,
  output logic signed [sqc_pkg::DataW-1:0] out_mean_stress,
  output logic signed [sqc_pkg::DataW-1:0] out_dev_xx,
  output logic signed [sqc_pkg::DataW-1:0] out_dev_yy,
  output logic signed [sqc_pkg::DataW-1:0] out_dev_zz,
  output logic        [sqc_pkg::RootW-1:0] out_dev_norm,
  output logic        [sqc_pkg::RootW-1:0] out_equiv_stress
);
  import sqc_pkg::*;

  localparam int Lat      = 39;
  localparam int PayDepth = 35;
  localparam int CmpDepth = 3;

  logic [Lat-1:0]   vld_r, vld_nxt;
  logic             accept;
  logic [DataW-1:0] cmp_r [0:CmpDepth-1][0:NumLane-1];
  logic [DataW-1:0] mean;
  logic [DevW-1:0]  lane_in_r [0:NumLane-1];
  logic [SqW-1:0]   lane_sq   [0:NumLane-1];
  pay_t             pay_r [0:PayDepth-1];
  pay_t             pay_nxt;
  logic [DevW-1:0]  dev [0:2];
  logic [AccW-1:0]  acc_r;
  logic [SqInW-1:0] norm_x_r, equiv_x_r;
  logic [SqInW:0]   tri_acc;
  logic [RootW-1:0] norm_root, equiv_root;
  logic             norm_sat, equiv_sat;
  logic [DataW-1:0] mean_o_r, dxx_o_r, dyy_o_r, dzz_o_r;
  logic [RootW-1:0] norm_o_r, equiv_o_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance the valid line
  assign vld_nxt = {vld_r[Lat-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold the components while the mean is formed
  always_ff @(posedge clk) begin
    cmp_r[0][0] <= in_stress_xx;
    cmp_r[0][1] <= in_stress_yy;
    cmp_r[0][2] <= in_stress_zz;
    cmp_r[0][3] <= in_shear_a;
    cmp_r[0][4] <= in_shear_b;
    cmp_r[0][5] <= in_shear_c;
    for (int s = 1; s < CmpDepth; s++) begin
      cmp_r[s] <= cmp_r[s-1];
    end
  end

  sqc_mean u_mean (
    .clk      (clk),
    .in_xx    (in_stress_xx),
    .in_yy    (in_stress_yy),
    .in_zz    (in_stress_zz),
    .out_mean (mean)
  );

  // Form exact deviatoric normals
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dev[i] = DevW'($signed(cmp_r[CmpDepth-1][i])) - DevW'($signed(mean));
    end
  end

  function automatic logic [DataW-1:0] clamp_dev(input logic [DevW-1:0] v);
    if (v[DevW-1] != v[DevW-2]) begin
      clamp_dev = v[DevW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      clamp_dev = v[DataW-1:0];
    end
  endfunction

  assign pay_nxt = '{mean: mean, dev_xx: clamp_dev(dev[0]),
                     dev_yy: clamp_dev(dev[1]), dev_zz: clamp_dev(dev[2])};

  // Load lane operands and the payload line
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lane_in_r[i]   <= dev[i];
      lane_in_r[i+3] <= DevW'($signed(cmp_r[CmpDepth-1][i+3]));
    end
    pay_r[0] <= pay_nxt;
    for (int s = 1; s < PayDepth; s++) begin
      pay_r[s] <= pay_r[s-1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < NumLane; g++) begin : g_lane
      sqc_lane u_lane (
        .clk    (clk),
        .in_val (lane_in_r[g]),
        .out_sq (lane_sq[g])
      );
    end
  endgenerate

  // Merge lanes: shear squares count twice
  always_ff @(posedge clk) begin
    acc_r <= AccW'(lane_sq[0]) + AccW'(lane_sq[1]) + AccW'(lane_sq[2])
           + ((AccW'(lane_sq[3]) + AccW'(lane_sq[4]) + AccW'(lane_sq[5])) << 1);
  end

  // Scale by 1.5 for the equivalent stress
  assign tri_acc = {acc_r, 1'b0} + (SqInW+1)'(acc_r);

  always_ff @(posedge clk) begin
    norm_x_r  <= SqInW'(acc_r);
    equiv_x_r <= tri_acc[SqInW:1];
  end

  sqc_isqrt u_norm (
    .clk      (clk),
    .in_x     (norm_x_r),
    .out_root (norm_root),
    .out_sat  (norm_sat)
  );

  sqc_isqrt u_equiv (
    .clk      (clk),
    .in_x     (equiv_x_r),
    .out_root (equiv_root),
    .out_sat  (equiv_sat)
  );

  // Register results with saturation
  always_ff @(posedge clk) begin
    mean_o_r  <= pay_r[PayDepth-1].mean;
    dxx_o_r   <= pay_r[PayDepth-1].dev_xx;
    dyy_o_r   <= pay_r[PayDepth-1].dev_yy;
    dzz_o_r   <= pay_r[PayDepth-1].dev_zz;
    norm_o_r  <= norm_sat ? {RootW{1'b1}} : norm_root;
    equiv_o_r <= equiv_sat ? {RootW{1'b1}} : equiv_root;
  end

  assign out_strobe       = vld_r[Lat-1];
  assign out_mean_stress  = mean_o_r;
  assign out_dev_xx       = dxx_o_r;
  assign out_dev_yy       = dyy_o_r;
  assign out_dev_zz       = dzz_o_r;
  assign out_dev_norm     = norm_o_r;
  assign out_equiv_stress = equiv_o_r;
endmodule
